// File: src/pttr_pkg.sv
// Shared types and constants of the per-thread call stack tracker.
package pttr_pkg;

    localparam int SLOT_IN_W = 6;
    localparam int FUNC_IN_W = 10;
    localparam int PARENT_W = 10;
    localparam int OUTCOME_W = 3;

    localparam int THREAD_SLOTS_DEF = 64;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int FUNC_BITS_DEF = 10;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_RET_EMPTY  = 3'd0,
        OC_FIRST_PUSH = 3'd1,
        OC_POP_PARENT = 3'd2,
        OC_POP_EMPTY  = 3'd3,
        OC_PUSH       = 3'd4,
        OC_OVERFLOW   = 3'd5
    } t_outcome;

endpackage

// File: src/pttr_event_if.sv
// Valid/ready channel that carries one trace event item.
interface pttr_event_if;
    logic                             valid;
    logic                             ready;
    logic [pttr_pkg::SLOT_IN_W-1:0]   thread_slot;
    logic [pttr_pkg::FUNC_IN_W-1:0]   func_index;
    logic                             is_return;

    modport source (output valid, output thread_slot, output func_index, output is_return,
                    input ready);
    modport sink (input valid, input thread_slot, input func_index, input is_return,
                  output ready);
endinterface

// File: src/pttr_result_if.sv
// Valid/ready channel that carries one tracker result item.
interface pttr_result_if;
    logic                             valid;
    logic                             ready;
    logic [pttr_pkg::PARENT_W-1:0]    parent_func;
    pttr_pkg::t_outcome               outcome;

    modport source (output valid, output parent_func, output outcome, input ready);
    modport sink (input valid, input parent_func, input outcome, output ready);
endinterface

// File: src/per_thread_call_stack_tracker_core.sv
// Per-thread shadow call stack tracker: fill and stack memories, three-stage pipeline.
//
// The block takes one trace event item per cycle while the output does not stall, and
// gives one result item for each, in order. An event is registered in the first stage,
// then in the second stage, then in the result register. An item first reads its slot's
// fill count, then reads the top two stack entries at that level, then decides the
// outcome and writes the stack and fill memories; results of a preceding item of the
// same slot are forwarded so that back-to-back events on one thread need no stall.
// The pipeline only halts when the result register is full and not taken. After
// reset a clearing pass zeroes the fill count of each slot in turn, and no event
// is accepted until it is done. Slots at or above THREAD_SLOTS leave all stacks
// untouched and report a return on an empty stack.
module per_thread_call_stack_tracker_core #(
    parameter int THREAD_SLOTS = pttr_pkg::THREAD_SLOTS_DEF,
    parameter int STACK_DEPTH  = pttr_pkg::STACK_DEPTH_DEF,
    parameter int FUNC_BITS    = pttr_pkg::FUNC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pttr_event_if.sink            i_event,
    pttr_result_if.source         o_result
);

    localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int LVL_W  = $clog2(STACK_DEPTH);
    localparam int SIN_W  = pttr_pkg::SLOT_IN_W;
    localparam int PW     = pttr_pkg::PARENT_W;

    logic [FILL_W-1:0]    fill_mem [THREAD_SLOTS];
    logic [FUNC_BITS-1:0] stack_mem [THREAD_SLOTS][STACK_DEPTH];

    logic                 r_clr_busy;
    logic [SLOT_W-1:0]    r_clr_idx;

    logic                 r_s1_v;
    logic [SIN_W-1:0]     r_s1_slot;
    logic                 r_s1_inr;
    logic [FUNC_BITS-1:0] r_s1_func;
    logic                 r_s1_ret;
    logic [FILL_W-1:0]    r_s1_fill;

    logic                 r_s2_v;
    logic [SIN_W-1:0]     r_s2_slot;
    logic                 r_s2_inr;
    logic [FUNC_BITS-1:0] r_s2_func;
    logic                 r_s2_ret;
    logic [FILL_W-1:0]    r_s2_fill;
    logic [FUNC_BITS-1:0] r_s2_top;
    logic [FUNC_BITS-1:0] r_s2_sec;

    logic                 r_o_valid;
    logic [PW-1:0]        r_o_parent;
    pttr_pkg::t_outcome   r_o_outcome;

    logic                 w_out_load;
    logic                 w_s2_move;
    logic                 w_s1_move;
    logic                 w_accept;
    logic                 w_s2_wr;
    logic                 w_s2_sw;
    logic                 w_s2_fwd;
    logic [SLOT_W-1:0]    w_in_idx;
    logic [SLOT_W-1:0]    w_s1_idx;
    logic [SLOT_W-1:0]    w_s2_idx;
    logic [FILL_W-1:0]    w_s1_fill;
    logic [FILL_W-1:0]    w_fill_m1;
    logic [FILL_W-1:0]    w_fill_m2;
    logic [LVL_W-1:0]     w_lvl_top;
    logic [LVL_W-1:0]     w_lvl_sec;
    logic [LVL_W-1:0]     w_wr_lvl;

    logic [FILL_W-1:0]    w_new_fill;
    logic                 w_push;
    logic [FUNC_BITS-1:0] w_parent;
    pttr_pkg::t_outcome   w_outcome;

    assign w_out_load = !r_o_valid || o_result.ready;
    assign w_s2_move  = r_s2_v && w_out_load;
    assign w_s1_move  = r_s1_v && (!r_s2_v || w_s2_move);
    assign i_event.ready = !r_clr_busy && (!r_s1_v || w_s1_move);
    assign w_accept   = i_event.valid && i_event.ready;

    assign w_in_idx = SLOT_W'(i_event.thread_slot);
    assign w_s1_idx = SLOT_W'(r_s1_slot);
    assign w_s2_idx = SLOT_W'(r_s2_slot);

    // The decision for the item in the last stage.
    always_comb begin
        w_new_fill = r_s2_fill;
        w_push     = 1'b0;
        w_parent   = '0;
        w_outcome  = pttr_pkg::OC_RET_EMPTY;
        if (r_s2_fill == '0) begin
            if (!r_s2_ret) begin
                w_push     = 1'b1;
                w_new_fill = FILL_W'(1);
                w_outcome  = pttr_pkg::OC_FIRST_PUSH;
            end
        end else if (r_s2_top == r_s2_func) begin
            w_new_fill = r_s2_fill - FILL_W'(1);
            if (w_new_fill != '0) begin
                w_parent  = r_s2_sec;
                w_outcome = pttr_pkg::OC_POP_PARENT;
            end else begin
                w_outcome = pttr_pkg::OC_POP_EMPTY;
            end
        end else begin
            w_parent = r_s2_top;
            if (r_s2_fill >= FILL_W'(STACK_DEPTH)) begin
                w_outcome = pttr_pkg::OC_OVERFLOW;
            end else begin
                w_push     = 1'b1;
                w_new_fill = r_s2_fill + FILL_W'(1);
                w_outcome  = pttr_pkg::OC_PUSH;
            end
        end
        if (!r_s2_inr) begin
            w_new_fill = r_s2_fill;
            w_push     = 1'b0;
            w_parent   = '0;
            w_outcome  = pttr_pkg::OC_RET_EMPTY;
        end
    end

    assign w_wr_lvl = r_s2_fill[LVL_W-1:0];
    assign w_s2_wr  = w_s2_move && r_s2_inr;
    assign w_s2_sw  = w_s2_wr && w_push;

    // The middle stage sees the fill left by the item ahead of it on the same slot.
    assign w_s2_fwd  = r_s2_v && r_s2_inr && (r_s2_slot == r_s1_slot);
    assign w_s1_fill = w_s2_fwd ? w_new_fill : r_s1_fill;
    assign w_fill_m1 = w_s1_fill - FILL_W'(1);
    assign w_fill_m2 = w_s1_fill - FILL_W'(2);
    assign w_lvl_top = w_fill_m1[LVL_W-1:0];
    assign w_lvl_sec = w_fill_m2[LVL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            fill_mem[r_clr_idx] <= '0;
        end else if (w_s2_wr) begin
            fill_mem[w_s2_idx] <= w_new_fill;
        end
        if (w_accept) begin
            if (w_s2_wr && (r_s2_slot == i_event.thread_slot)) begin
                r_s1_fill <= w_new_fill;
            end else begin
                r_s1_fill <= fill_mem[w_in_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_sw) begin
            stack_mem[w_s2_idx][w_wr_lvl] <= r_s2_func;
        end
        if (w_s1_move) begin
            if (w_s2_sw && (w_s2_idx == w_s1_idx) && (w_wr_lvl == w_lvl_top)) begin
                r_s2_top <= r_s2_func;
            end else begin
                r_s2_top <= stack_mem[w_s1_idx][w_lvl_top];
            end
            if (w_s2_sw && (w_s2_idx == w_s1_idx) && (w_wr_lvl == w_lvl_sec)) begin
                r_s2_sec <= r_s2_func;
            end else begin
                r_s2_sec <= stack_mem[w_s1_idx][w_lvl_sec];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_slot <= i_event.thread_slot;
            r_s1_inr  <= (32'(i_event.thread_slot) < THREAD_SLOTS);
            r_s1_func <= FUNC_BITS'(i_event.func_index);
            r_s1_ret  <= i_event.is_return;
        end
        if (w_s1_move) begin
            r_s2_slot <= r_s1_slot;
            r_s2_inr  <= r_s1_inr;
            r_s2_func <= r_s1_func;
            r_s2_ret  <= r_s1_ret;
            r_s2_fill <= w_s1_fill;
        end
        if (w_s2_move) begin
            r_o_parent  <= PW'(w_parent);
            r_o_outcome <= w_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_idx == SLOT_W'(THREAD_SLOTS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_idx <= r_clr_idx + SLOT_W'(1);
            end
            if (w_accept) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_move) begin
                r_s2_v <= 1'b1;
            end else if (w_s2_move) begin
                r_s2_v <= 1'b0;
            end
            if (w_s2_move) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.parent_func = r_o_parent;
    assign o_result.outcome     = r_o_outcome;

endmodule
